### rtl/mba_pkg.sv
package mba_pkg;

    // Defaults and fixed widths
    localparam int CHANNELS_DEFAULT = 8;
    localparam int CHAN_W           = 8;
    localparam int SAMPLE_W         = 16;
    localparam int LEN_W            = 16;
    localparam int SUM_W            = 32;
    localparam int QUEUE_DEPTH      = 2;
    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = 16'd10;

    // Input word
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [SAMPLE_W-1:0] mean;
        logic                bad_index;
    } out_word_t;

    // Classified work handed from front to back
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
        logic                bad;
        logic                emit;
    } task_t;

endpackage

### rtl/mba_ram.sv
module mba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mba_front.sv
module mba_front #(
    parameter int CHANNELS = mba_pkg::CHANNELS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid,
    input  logic                       queue_full,
    input  mba_pkg::in_word_t          word,
    input  logic                       block_length_we,
    input  logic [mba_pkg::LEN_W-1:0]  block_length_data,
    output logic                       stall,
    output logic                       push,
    output mba_pkg::task_t             task_word,
    output logic [mba_pkg::LEN_W-1:0]  block_length
);

    localparam logic [mba_pkg::CHAN_W-1:0] LAST_CH = mba_pkg::CHAN_W'(CHANNELS - 1);
    localparam logic [mba_pkg::CHAN_W-1:0] NUM_CH  = mba_pkg::CHAN_W'(CHANNELS);

    logic [mba_pkg::LEN_W-1:0] frame_count_reg, frame_count_next;
    logic [mba_pkg::LEN_W-1:0] block_length_reg, block_length_next;
    logic [mba_pkg::LEN_W:0]   count_inc;
    logic                      bad;
    logic                      emit;

    assign stall = queue_full;
    assign push  = valid && !queue_full;

    // Classify the word against the frame counter
    assign count_inc = {1'b0, frame_count_reg} + {{mba_pkg::LEN_W{1'b0}}, 1'b1};
    assign bad       = (word.channel >= NUM_CH);
    assign emit      = (block_length_reg != '0) && (count_inc == {1'b0, block_length_reg});

    always_comb
    begin
        task_word.channel = word.channel;
        task_word.sample  = word.sample;
        task_word.bad     = bad;
        task_word.emit    = emit;
    end

    // Frame counter advances after the last channel
    always_comb
    begin
        frame_count_next = frame_count_reg;
        if (push && !bad && (word.channel == LAST_CH))
        begin
            frame_count_next = emit ? '0 : count_inc[mba_pkg::LEN_W-1:0];
        end
        block_length_next = block_length_we ? block_length_data : block_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= '0;
            block_length_reg <= mba_pkg::BLOCK_LENGTH_RESET;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            block_length_reg <= block_length_next;
        end
    end

    assign block_length = block_length_reg;

endmodule

### rtl/mba_fifo.sv
module mba_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mba_pkg::task_t push_word,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output mba_pkg::task_t head
);

    localparam int PW = (mba_pkg::QUEUE_DEPTH > 1) ? $clog2(mba_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(mba_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(mba_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(mba_pkg::QUEUE_DEPTH - 1);

    mba_pkg::task_t  slot_reg [mba_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/mba_back.sv
module mba_back #(
    parameter int CHANNELS = mba_pkg::CHANNELS_DEFAULT,
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       queue_valid,
    input  mba_pkg::task_t             queue_head,
    input  logic [mba_pkg::LEN_W-1:0]  block_length,
    input  logic                       stall,
    output logic                       pop,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [mba_pkg::SUM_W-1:0]  ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [mba_pkg::SUM_W-1:0]  ram_rdata,
    output logic                       valid,
    output mba_pkg::out_word_t         word
);

    localparam int SW = mba_pkg::SUM_W;
    localparam int LW = mba_pkg::LEN_W;
    localparam int NW = $clog2(SW);
    localparam logic [NW-1:0] LAST_STEP = NW'(SW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_SEND
    } state_t;

    state_t              state_reg, state_next;
    mba_pkg::task_t      task_reg, task_next;
    logic [SW-1:0]       dq_reg, dq_next;
    logic [LW-1:0]       rem_reg, rem_next;
    logic [NW-1:0]       step_reg, step_next;
    logic [CHANNELS-1:0] written_reg, written_next;
    logic                out_valid_reg, out_valid_next;
    mba_pkg::out_word_t  out_word_reg, out_word_next;

    logic [AW-1:0]       task_idx;
    logic [SW-1:0]       old_sum;
    logic [SW-1:0]       new_sum;
    logic [LW:0]         shifted;
    logic                fits;
    logic                out_free;

    assign task_idx = task_reg.channel[AW-1:0];
    assign out_free = !out_valid_reg || !stall;

    // Sum update; an entry never written reads as zero
    assign old_sum = written_reg[task_idx] ? ram_rdata : '0;
    assign new_sum = old_sum + {{(SW - mba_pkg::SAMPLE_W){1'b0}}, task_reg.sample};

    // One restoring divide step per cycle
    assign shifted = {rem_reg, dq_reg[SW-1]};
    assign fits    = (shifted >= {1'b0, block_length});

    // Read is issued as the word leaves the queue
    assign pop       = (state_reg == S_IDLE) && queue_valid;
    assign ram_re    = pop;
    assign ram_raddr = queue_head.channel[AW-1:0];

    assign ram_we    = (state_reg == S_ADD);
    assign ram_waddr = task_idx;
    assign ram_wdata = task_reg.emit ? '0 : new_sum;

    always_comb
    begin
        state_next     = state_reg;
        task_next      = task_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        written_next   = written_reg;
        out_valid_next = out_valid_reg && stall;
        out_word_next  = out_word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (queue_valid)
                begin
                    task_next  = queue_head;
                    state_next = queue_head.bad ? S_SEND : S_ADD;
                end
            end
            S_ADD:
            begin
                written_next[task_idx] = 1'b1;
                if (task_reg.emit)
                begin
                    dq_next    = new_sum;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                rem_next  = fits ? LW'(shifted - {1'b0, block_length}) : shifted[LW-1:0];
                dq_next   = {dq_reg[SW-2:0], fits};
                step_next = step_reg + NW'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.out_channel = task_reg.channel;
                    out_word_next.mean        = task_reg.bad ? '0 : dq_reg[mba_pkg::SAMPLE_W-1:0];
                    out_word_next.bad_index   = task_reg.bad;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            task_reg      <= '0;
            dq_reg        <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            task_reg      <= task_next;
            dq_reg        <= dq_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign valid = out_valid_reg;
    assign word  = out_word_reg;

endmodule

### rtl/multichannel_block_averager_top.sv
// Block-average decimator over CHANNELS interleaved channels.
// Input channel (sample_valid / sample_stall / sample_word): one word per
// sample, tagged with its channel, channels 0..CHANNELS-1 in order per frame.
// Result channel (result_valid / result_stall / result_word): one word for
// each sample of the frame that closes a block (the channel mean), and one
// for every sample with an out-of-range channel (bad_index set, mean zero).
// block_length_we / block_length_data set the frame count of a block; write
// it only while the block is idle.
// A sample that only accumulates passes through the back end as a queue pop
// with sum read, then an add and write back. An emitting sample goes on to
// the bit-serial 32-by-16 divider and then a send step; a bad-index sample
// goes from the pop straight to the send step. A two-word queue sits between
// classification and the back end, so samples keep being taken while
// a long divide runs or the result is stalled.
// Reset clears the sums (by per-channel written bits), the frame counter and
// the queue, and sets block_length to 10.
// While result_stall is high the result word is held and the back end waits
// in its send step; once the queue fills, sample_stall rises.
module multichannel_block_averager_top #(
    parameter int CHANNELS = mba_pkg::CHANNELS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  mba_pkg::in_word_t          sample_word,
    output logic                       result_valid,
    input  logic                       result_stall,
    output mba_pkg::out_word_t         result_word,
    input  logic                       block_length_we,
    input  logic [mba_pkg::LEN_W-1:0]  block_length_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                          push, pop, queue_full, queue_valid;
    mba_pkg::task_t                push_word, queue_head;
    logic [mba_pkg::LEN_W-1:0]     block_length;
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [mba_pkg::SUM_W-1:0]     ram_wdata, ram_rdata;

    // Classification and frame counting
    mba_front #(.CHANNELS(CHANNELS)) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .valid             (sample_valid),
        .queue_full        (queue_full),
        .word              (sample_word),
        .block_length_we   (block_length_we),
        .block_length_data (block_length_data),
        .stall             (sample_stall),
        .push              (push),
        .task_word         (push_word),
        .block_length      (block_length)
    );

    // Decoupling queue
    mba_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head      (queue_head)
    );

    // Accumulate, divide, send
    mba_back #(.CHANNELS(CHANNELS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_valid  (queue_valid),
        .queue_head   (queue_head),
        .block_length (block_length),
        .stall        (result_stall),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .valid        (result_valid),
        .word         (result_word)
    );

    // Per-channel sums
    mba_ram #(.WIDTH(mba_pkg::SUM_W), .DEPTH(CHANNELS)) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/mba_checker.sv
module mba_checker #(
    parameter int CHANNELS = mba_pkg::CHANNELS_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_valid,
    input logic                       sample_stall,
    input mba_pkg::in_word_t          sample_word,
    input logic                       result_valid,
    input logic                       result_stall,
    input mba_pkg::out_word_t         result_word,
    input logic                       block_length_we,
    input logic [mba_pkg::LEN_W-1:0]  block_length_data
);

    localparam logic [mba_pkg::CHAN_W-1:0] NUM_CH = mba_pkg::CHAN_W'(CHANNELS);

    // A stalled result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("result word changed while stalled");

    // Error words carry a zero mean
    a_bad_mean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.bad_index |-> result_word.mean == '0)
        else $error("bad-index word with nonzero mean");

    // The error flag matches the reported channel
    a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.bad_index == (result_word.out_channel >= NUM_CH))
        else $error("bad_index disagrees with out_channel");

    // A result never rises in the first cycle out of reset
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(rst_n))
        else $error("result right after reset");

endmodule

bind multichannel_block_averager_top mba_checker #(.CHANNELS(CHANNELS)) u_mba_checker (.*);

### tb/tb_top.sv
module tb_top;

    localparam int NUM_CH         = mba_pkg::CHANNELS_DEFAULT;
    localparam int CH_AW          = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int CHAN_W         = mba_pkg::CHAN_W;
    localparam int SAMPLE_W       = mba_pkg::SAMPLE_W;
    localparam int LEN_W          = mba_pkg::LEN_W;
    localparam int SUM_W          = mba_pkg::SUM_W;
    localparam int SETTLE_CYCLES  = 40;     // longest divide plus margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_SAMPLES = 750;

    // Clock, reset and DUT inputs, all known from time zero
    logic                clk               = 1'b0;
    logic                rst_n             = 1'b0;
    logic                sample_valid      = 1'b0;
    mba_pkg::in_word_t   sample_word       = '0;
    logic                result_stall      = 1'b0;
    logic                block_length_we   = 1'b0;
    logic [LEN_W-1:0]    block_length_data = '0;
    logic                sample_stall;
    logic                result_valid;
    mba_pkg::out_word_t  result_word;

    // Predictor state
    logic [SUM_W-1:0]    ch_sum [NUM_CH];
    logic [LEN_W-1:0]    frame_cnt;
    logic [LEN_W-1:0]    blk_len;
    mba_pkg::out_word_t  expected_means [$];

    // Run bookkeeping
    int                  errors          = 0;
    int                  samples_sent    = 0;
    int                  results_checked = 0;
    int                  stall_left      = 0;
    int                  quiet_cycles    = 0;
    logic                send_gaps       = 1'b1;
    logic                stall_gaps      = 1'b1;

    always #5 clk = ~clk;

    multichannel_block_averager_top #(
        .CHANNELS(NUM_CH)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample_word       (sample_word),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result_word       (result_word),
        .block_length_we   (block_length_we),
        .block_length_data (block_length_data)
    );

    // Accumulate one accepted sample word; queue the mean it produces, if any
    function automatic void accumulate_sample(mba_pkg::in_word_t w);
        mba_pkg::out_word_t r;
        logic [LEN_W:0]     next_cnt;
        logic               emit;
        logic [SUM_W-1:0]   quo;
        logic [CH_AW-1:0]   idx;
        next_cnt = {1'b0, frame_cnt} + {{LEN_W{1'b0}}, 1'b1};
        emit     = (blk_len != '0) && (next_cnt == {1'b0, blk_len});
        idx      = w.channel[CH_AW-1:0];
        if (w.channel >= NUM_CH)
        begin
            // bad index: no state change, error word
            r.out_channel = w.channel;
            r.mean        = '0;
            r.bad_index   = 1'b1;
            expected_means.push_back(r);
        end
        else
        begin
            ch_sum[idx] = ch_sum[idx] + {{(SUM_W-SAMPLE_W){1'b0}}, w.sample};
            if (emit)
            begin
                quo           = ch_sum[idx] / {{(SUM_W-LEN_W){1'b0}}, blk_len};
                r.out_channel = w.channel;
                r.mean        = quo[SAMPLE_W-1:0];
                r.bad_index   = 1'b0;
                expected_means.push_back(r);
                ch_sum[idx] = '0;
            end
            // frame advances on the last channel
            if (w.channel == NUM_CH - 1)
                frame_cnt = emit ? '0 : next_cnt[LEN_W-1:0];
        end
    endfunction

    // Sample values lean toward the extremes now and then
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else
            return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // Send one sample word; returns at the edge where it is accepted
    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int                gap;
        mba_pkg::in_word_t w;
        gap       = send_gaps ? $urandom_range(0, 9) : 0;
        w.channel = ch;
        w.sample  = smp;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_word  <= w;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        accumulate_sample(w);
        samples_sent++;
    endtask

    // One frame, channels in order, random samples
    task automatic send_frame();
        for (int ch = 0; ch < NUM_CH; ch++)
            send_sample(CHAN_W'(ch), draw_sample());
    endtask

    // One frame, channels in order, one sample value
    task automatic send_flat_frame(input logic [SAMPLE_W-1:0] smp);
        for (int ch = 0; ch < NUM_CH; ch++)
            send_sample(CHAN_W'(ch), smp);
    endtask

    // Stop sending and wait until every expected mean has come out
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Block length write, only once the block is idle
    task automatic write_block_length(input logic [LEN_W-1:0] len);
        drain_results();
        block_length_we   <= 1'b1;
        block_length_data <= len;
        @(posedge clk);
        block_length_we   <= 1'b0;
        blk_len = len;
    endtask

    // Field extremes and bad channel indexes under the reset length
    task automatic test_field_extremes();
        send_flat_frame('1);
        send_flat_frame('0);
        send_sample(CHAN_W'(NUM_CH), '1);
        send_sample(8'hFF, '1);
        send_sample(8'h80, 16'h5A5A);
        send_sample(8'h7F, '0);
    endtask

    // Finish the block under the reset length of 10 frames
    task automatic test_reset_length();
        while (frame_cnt != 0)
            send_frame();
    endtask

    // Length 1: every valid word emits its own sample
    task automatic test_length_one();
        write_block_length(16'd1);
        send_flat_frame('1);
        send_frame();
    endtask

    // Length 0: nothing emits while the frame count keeps running
    task automatic test_length_zero();
        write_block_length('0);
        send_frame();
        send_frame();
        write_block_length(frame_cnt + 16'd2);
        while (frame_cnt != 0)
            send_frame();
    endtask

    // Out-of-order words pile up on one channel: quotient wider than the mean
    task automatic test_wide_mean();
        write_block_length(16'd2);
        repeat (6) send_sample(8'd0, '1);
        send_sample(CHAN_W'(NUM_CH - 1), draw_sample());
        send_sample(8'd0, '1);
        send_sample(8'd3, draw_sample());
        send_sample(8'd2, draw_sample());
        send_sample(CHAN_W'(NUM_CH - 1), draw_sample());
    endtask

    // Length lowered below the count: the count runs on with no mean.
    // Then the largest length for one frame.
    task automatic test_length_lowered();
        write_block_length(16'd10);
        while (frame_cnt != 16'd5)
            send_sample(CHAN_W'(NUM_CH - 1), draw_sample());
        write_block_length(16'd3);
        send_gaps = 1'b0;
        repeat (4) send_sample(CHAN_W'(NUM_CH - 1), '1);
        send_sample(8'd0, '1);
        send_gaps = 1'b1;
        write_block_length('1);
        send_frame();
    endtask

    // Random phases: mostly clean frames, some stray and broken ones
    task automatic test_random_mix();
        int               start_count;
        int               phase_end;
        int               pick;
        logic [LEN_W-1:0] len;
        start_count = samples_sent;
        while (samples_sent - start_count < RANDOM_SAMPLES)
        begin
            if (frame_cnt == 0 && $urandom_range(0, 3) == 0)
                len = 16'd1;
            else
                len = frame_cnt + LEN_W'($urandom_range(1, 6));
            write_block_length(len);
            send_gaps  = ($urandom_range(0, 3) != 0);
            stall_gaps = ($urandom_range(0, 3) != 0);
            phase_end  = samples_sent + $urandom_range(40, 100);
            while (samples_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_frame();
                else if (pick < 90)
                    send_sample(CHAN_W'($urandom_range(0, 255)), draw_sample());
                else
                begin
                    // broken frame: channels dropped or repeated
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        if ($urandom_range(0, 5) != 0)
                            send_sample(CHAN_W'(ch), draw_sample());
                        if ($urandom_range(0, 7) == 0)
                            send_sample(CHAN_W'(ch), draw_sample());
                    end
                end
            end
        end
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
    endtask

    // Result checker and result-side stall
    always @(posedge clk)
    begin : check_results
        mba_pkg::out_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_means.size() == 0)
            begin
                $display("%0t: expected no result, actual channel %0d mean %0d bad_index %0b",
                         $time, result_word.out_channel, result_word.mean,
                         result_word.bad_index);
                errors++;
            end
            else
            begin
                want = expected_means.pop_front();
                if (result_word.out_channel !== want.out_channel)
                begin
                    $display("%0t: out_channel expected %0d actual %0d",
                             $time, want.out_channel, result_word.out_channel);
                    errors++;
                end
                if (result_word.mean !== want.mean)
                begin
                    $display("%0t: mean expected %0d actual %0d",
                             $time, want.mean, result_word.mean);
                    errors++;
                end
                if (result_word.bad_index !== want.bad_index)
                begin
                    $display("%0t: bad_index expected %0b actual %0b",
                             $time, want.bad_index, result_word.bad_index);
                    errors++;
                end
                results_checked++;
            end
            stall_left = stall_gaps ? $urandom_range(0, 9) : 0;
        end
        else if (stall_left != 0)
            stall_left--;
        result_stall <= (stall_left != 0);
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || block_length_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
            ch_sum[ch] = '0;
        frame_cnt = '0;
        blk_len   = mba_pkg::BLOCK_LENGTH_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_reset_length();
        test_length_one();
        test_length_zero();
        test_wide_mean();
        test_length_lowered();
        test_random_mix();
        drain_results();

        $display("Sent %0d sample words, checked %0d result words", samples_sent,
                 results_checked);
        $display("Block lengths 0, 1, 2, 10, 65535 and random; lowered length, wide means "
                 , "and bad indexes");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
